// ----- src/assert_macros.svh -----
// Assertion helpers for the sparse row product accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, c, r, a, b)
`define ASSERT_NEXT(lbl, c, r, a, b)
`endif
`endif

// ----- src/srpa_pkg.sv -----
`default_nettype none
package srpa_pkg;

  localparam logic [2:0] KIND_B_PTR   = 3'd0;
  localparam logic [2:0] KIND_B_ENTRY = 3'd1;
  localparam logic [2:0] KIND_MAP     = 3'd2;
  localparam logic [2:0] KIND_A_NZ    = 3'd3;
  localparam logic [2:0] KIND_EMPTY   = 3'd4;

  localparam logic REG_USE_MAP = 1'b0;
  localparam logic REG_ZERO_TOL = 1'b1;

  localparam int ACC_W = 48;
  localparam logic signed [63:0] ROUND_HALF = 64'sd32768;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PTR0,
    S_PTR1,
    S_WALK_RD,
    S_WALK_MUL,
    S_WALK_ADD,
    S_DRAIN_GO,
    S_DRAIN_RD,
    S_DRAIN_CHK,
    S_DRAIN_FIN
  } state_t;

endpackage
`default_nettype wire

// ----- src/srpa_mac.sv -----
`default_nettype none
// Shared multiply-accumulate: registered product, then round, add, saturate.
module srpa_mac (
  input  wire logic                               clk,
  input  wire logic                               load,
  input  wire logic signed [31:0]                 a,
  input  wire logic signed [31:0]                 b,
  input  wire logic signed [srpa_pkg::ACC_W-1:0]  acc_in,
  output logic signed [srpa_pkg::ACC_W-1:0]       sum
);
  import srpa_pkg::*;

  logic signed [63:0] prod;
  logic signed [63:0] q;
  logic signed [ACC_W-1:0] rounded;
  logic signed [ACC_W:0] wide;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= a * b;
    end
  end

  // round to nearest, ties up: floor((p + 2^15) / 2^16)
  always_comb begin
    q = prod + ROUND_HALF;
    rounded = ACC_W'(q >>> 16);
    wide = {acc_in[ACC_W-1], acc_in} + {rounded[ACC_W-1], rounded};
    if (wide[ACC_W] != wide[ACC_W-1]) begin
      sum = wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sum = wide[ACC_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- src/sparse_row_product_accumulator.sv -----
`default_nettype none
// Gustavson row-by-row sparse product C = A*B. Load B (row pointers, entries)
// and the optional column remap with kinds 0..2; busy stays low for these.
// An A nonzero (kind 3) with its column in range goes busy: the pointer
// memory is read twice, then each entry of the matching B row goes through
// one shared 32x32 multiplier and, if its column is in range, one 48-bit
// saturating adder. A row end (row_end on kind 3, or kind 4) then drains the
// touched columns, most recent first. Results come out one per cycle at most,
// each held on the ports for exactly one cycle with strobe high; the receiver
// cannot stall them, so it must take every strobe. A row that emits nothing
// gives one marker with present=0 and last=1. Configuration writes are taken
// at any cycle but should only be issued while busy is low.
module sparse_row_product_accumulator #(
  parameter int NUM_COLUMNS = 64,
  parameter int B_ENTRIES   = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         kind,
  input  wire logic [10:0]        index,
  input  wire logic [6:0]         column,
  input  wire logic [15:0]        mapped_column,
  input  wire logic signed [31:0] value,
  input  wire logic               row_end,
  input  wire logic               write_enable,
  input  wire logic               write_index,
  input  wire logic [30:0]        write_data,
  output logic                    strobe,
  output logic [15:0]             out_column,
  output logic signed [47:0]      out_value,
  output logic                    present,
  output logic                    last
);
  import srpa_pkg::*;

  localparam int CW = $clog2(NUM_COLUMNS);
  localparam int PW = $clog2(NUM_COLUMNS + 1);
  localparam int BW = $clog2(B_ENTRIES);
  localparam int KW = $clog2(B_ENTRIES + 1);
  localparam logic [CW:0] LIST_END = (CW + 1)'(NUM_COLUMNS);

  state_t state, state_next;

  logic use_map;
  logic [30:0] tol;

  logic accept;
  logic [31:0] colx, idxx, bcolx;
  logic signed [31:0] a_val;
  logic row_end_r;
  logic [PW-1:0] col_r;

  logic [10:0] ptr_mem [0:NUM_COLUMNS];
  logic [10:0] ptr_rd;
  logic [PW-1:0] ptr_raddr;
  logic [KW-1:0] ptr_clamped, start_k, end_k, k;
  logic [KW:0] k_inc;
  logic k_last;

  logic [6:0] b_col_mem [0:B_ENTRIES-1];
  logic [31:0] b_val_mem [0:B_ENTRIES-1];
  logic [6:0] b_col_rd;
  logic [31:0] b_val_rd;
  logic cb_ok;

  logic [15:0] remap_mem [0:NUM_COLUMNS-1];
  logic [15:0] remap_rd;
  logic signed [47:0] acc_mem [0:NUM_COLUMNS-1];
  logic signed [47:0] acc_rd;
  logic [CW:0] link_mem [0:NUM_COLUMNS-1];
  logic [CW:0] link_rd;
  logic [CW-1:0] acc_raddr, cb_r;

  logic [NUM_COLUMNS-1:0] touched;
  logic [CW:0] head, node;

  logic signed [47:0] mac_base, mac_sum;
  logic [47:0] mag;
  logic qualify;

  logic pend_valid;
  logic [15:0] pend_col;
  logic signed [47:0] pend_val;

  logic emit, emit_present, emit_last;
  logic [15:0] emit_col;
  logic signed [47:0] emit_val;
  logic [15:0] cand_col;
  state_t done_state;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign colx = 32'(column);
  assign idxx = 32'(index);
  assign bcolx = 32'(b_col_rd);
  assign cb_ok = bcolx < 32'(NUM_COLUMNS);
  assign k_inc = {1'b0, k} + 1'b1;
  assign k_last = k_inc >= {1'b0, end_k};
  assign ptr_clamped = (32'(ptr_rd) > 32'(B_ENTRIES)) ? KW'(B_ENTRIES) : KW'(ptr_rd);
  assign ptr_raddr = (state == S_IDLE) ? colx[PW-1:0] : col_r + 1'b1;
  assign acc_raddr = (state == S_WALK_MUL) ? bcolx[CW-1:0] : node[CW-1:0];
  assign mac_base = touched[cb_r] ? acc_rd : '0;
  assign mag = acc_rd[47] ? 48'(-acc_rd) : 48'(acc_rd);
  assign qualify = mag > {17'd0, tol};
  assign cand_col = use_map ? remap_rd : 16'(node);
  assign done_state = row_end_r ? S_DRAIN_GO : S_IDLE;

  srpa_mac u_mac (
    .clk    (clk),
    .load   (state == S_WALK_MUL),
    .a      (a_val),
    .b      (b_val_rd),
    .acc_in (mac_base),
    .sum    (mac_sum)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      use_map <= 1'b0;
      tol <= '0;
    end else if (write_enable) begin
      case (write_index)
        REG_USE_MAP:  use_map <= write_data[0];
        REG_ZERO_TOL: tol <= write_data;
        default: ;
      endcase
    end
  end

  // B and remap stores
  always_ff @(posedge clk) begin
    if (accept && kind == KIND_B_PTR && colx <= 32'(NUM_COLUMNS)) begin
      ptr_mem[colx[PW-1:0]] <= index;
    end
    ptr_rd <= ptr_mem[ptr_raddr];
  end

  always_ff @(posedge clk) begin
    if (accept && kind == KIND_B_ENTRY && idxx < 32'(B_ENTRIES)) begin
      b_col_mem[idxx[BW-1:0]] <= column;
      b_val_mem[idxx[BW-1:0]] <= value;
    end
    b_col_rd <= b_col_mem[k[BW-1:0]];
    b_val_rd <= b_val_mem[k[BW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept && kind == KIND_MAP && colx < 32'(NUM_COLUMNS)) begin
      remap_mem[colx[CW-1:0]] <= mapped_column;
    end
    remap_rd <= remap_mem[node[CW-1:0]];
  end

  // accumulators and links; touched marks a valid, linked column
  always_ff @(posedge clk) begin
    if (state == S_WALK_ADD) begin
      acc_mem[cb_r] <= mac_sum;
      if (!touched[cb_r]) begin
        link_mem[cb_r] <= head;
      end
    end
    acc_rd <= acc_mem[acc_raddr];
    link_rd <= link_mem[node[CW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      touched <= '0;
      head <= LIST_END;
      pend_valid <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state <= state_next;
      strobe <= emit;
      if (state == S_WALK_ADD && !touched[cb_r]) begin
        touched[cb_r] <= 1'b1;
        head <= {1'b0, cb_r};
      end
      if (state == S_DRAIN_CHK) begin
        touched[node[CW-1:0]] <= 1'b0;
        if (qualify) begin
          pend_valid <= 1'b1;
        end
      end
      if (state == S_DRAIN_FIN) begin
        head <= LIST_END;
        pend_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      a_val <= value;
      row_end_r <= row_end && (kind == KIND_A_NZ);
      col_r <= colx[PW-1:0];
    end
    if (state == S_PTR0) begin
      start_k <= ptr_clamped;
    end
    if (state == S_PTR1) begin
      end_k <= ptr_clamped;
      k <= start_k;
    end
    if (state == S_WALK_MUL) begin
      cb_r <= bcolx[CW-1:0];
      if (!cb_ok) begin
        k <= k_inc[KW-1:0];
      end
    end
    if (state == S_WALK_ADD) begin
      k <= k_inc[KW-1:0];
    end
    if (state == S_DRAIN_GO) begin
      node <= head;
    end
    if (state == S_DRAIN_CHK) begin
      node <= link_rd;
      if (qualify) begin
        pend_col <= cand_col;
        pend_val <= acc_rd;
      end
    end
    if (emit) begin
      out_column <= emit_col;
      out_value <= emit_val;
      present <= emit_present;
      last <= emit_last;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_A_NZ: begin
              if (colx < 32'(NUM_COLUMNS)) begin
                state_next = S_PTR0;
              end else if (row_end) begin
                state_next = S_DRAIN_GO;
              end
            end
            KIND_EMPTY: state_next = S_DRAIN_GO;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_PTR0: state_next = S_PTR1;
      S_PTR1: state_next = (start_k < ptr_clamped) ? S_WALK_RD : done_state;
      S_WALK_RD: state_next = S_WALK_MUL;
      S_WALK_MUL: begin
        if (cb_ok) begin
          state_next = S_WALK_ADD;
        end else begin
          state_next = k_last ? done_state : S_WALK_RD;
        end
      end
      S_WALK_ADD: state_next = k_last ? done_state : S_WALK_RD;
      S_DRAIN_GO: state_next = (head == LIST_END) ? S_DRAIN_FIN : S_DRAIN_RD;
      S_DRAIN_RD: state_next = S_DRAIN_CHK;
      S_DRAIN_CHK: state_next = (link_rd == LIST_END) ? S_DRAIN_FIN : S_DRAIN_RD;
      S_DRAIN_FIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // one-entry lookahead so the final emitted entry carries last
  always_comb begin
    emit = 1'b0;
    emit_col = pend_col;
    emit_val = pend_val;
    emit_present = 1'b1;
    emit_last = 1'b0;
    case (state)
      S_DRAIN_CHK: emit = qualify && pend_valid;
      S_DRAIN_FIN: begin
        emit = 1'b1;
        emit_last = 1'b1;
        if (!pend_valid) begin
          emit_col = '0;
          emit_val = '0;
          emit_present = 1'b0;
        end
      end
      default: emit = 1'b0;
    endcase
  end

`include "assert_macros.svh"

  `ASSERT_IMPL(a_marker_last, clk, rst, strobe && !present, last && out_value == 48'sd0)
  `ASSERT_NEXT(a_last_alone, clk, rst, strobe && last, !strobe)
  `ASSERT_IMPL(a_empty_list, clk, rst, head == LIST_END, touched == '0)

endmodule
`default_nettype wire

// ----- dv/sparse_row_product_checker.sv -----
`default_nettype none
// Watches the item, write and result ports, predicts the product rows and
// compares them with what the block emits.
module sparse_row_product_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [2:0]         kind,
  input  wire logic [10:0]        index,
  input  wire logic [6:0]         column,
  input  wire logic [15:0]        mapped_column,
  input  wire logic signed [31:0] value,
  input  wire logic               row_end,
  input  wire logic               write_enable,
  input  wire logic               write_index,
  input  wire logic [30:0]        write_data,
  input  wire logic               strobe,
  input  wire logic [15:0]        out_column,
  input  wire logic signed [47:0] out_value,
  input  wire logic               present,
  input  wire logic               last,
  output int                      errors,
  output int                      pending
);
  import srpa_pkg::*;

  localparam int NCOL     = 64;
  localparam int NSLOT    = 1024;
  localparam int LIST_END = NCOL;
  localparam int UNLINKED = NCOL + 1;
  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct packed {
    logic [15:0]        col;
    logic signed [47:0] val;
    logic               present;
    logic               last;
  } product_t;

  product_t      product_q[$];
  logic [10:0]   row_ptr[NCOL+1];
  logic [6:0]    slot_col[NSLOT];
  logic [31:0]   slot_val[NSLOT];
  logic [15:0]   remap[NCOL];
  longint        col_sum[NCOL];
  int            next_col[NCOL];
  int            head;
  int            touched;
  logic          map_on;
  logic [30:0]   tolerance;

  assign pending = product_q.size();

  initial begin
    errors = 0;
    foreach (row_ptr[i]) row_ptr[i] = '0;
    foreach (slot_col[i]) begin
      slot_col[i] = '0;
      slot_val[i] = '0;
    end
    foreach (remap[i]) remap[i] = '0;
  end

  task automatic report_miss(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic void clear_row();
    for (int i = 0; i < NCOL; i++) begin
      col_sum[i] = 0;
      next_col[i] = UNLINKED;
    end
    head = LIST_END;
    touched = 0;
  endfunction

  // Q32.32 product rounded half up to Q32.16, then saturating add.
  function automatic void mac(int c, longint a, longint b);
    longint q;
    longint s;
    q = a * b + 32768;
    s = col_sum[c] + (q >>> 16);
    if (s > SUM_MAX) s = SUM_MAX;
    if (s < SUM_MIN) s = SUM_MIN;
    col_sum[c] = s;
    if (next_col[c] == UNLINKED) begin
      next_col[c] = head;
      head = c;
      touched++;
    end
  endfunction

  function automatic void drain_row();
    product_t row_q[$];
    product_t e;
    int node;
    int nxt;
    longint mag;
    node = head;
    for (int j = 0; j < touched && node < NCOL; j++) begin
      mag = col_sum[node] < 0 ? -col_sum[node] : col_sum[node];
      nxt = next_col[node];
      if (mag > longint'(tolerance)) begin
        e.col = map_on ? remap[node] : 16'(node);
        e.val = col_sum[node][47:0];
        e.present = 1'b1;
        e.last = 1'b0;
        row_q.push_back(e);
      end
      next_col[node] = UNLINKED;
      col_sum[node] = 0;
      node = nxt;
    end
    head = LIST_END;
    touched = 0;
    if (row_q.size() == 0) begin
      e = '0;
      e.last = 1'b1;
      row_q.push_back(e);
    end else begin
      e = row_q.pop_back();
      e.last = 1'b1;
      row_q.push_back(e);
    end
    foreach (row_q[i]) product_q.push_back(row_q[i]);
  endfunction

  function automatic void take_item();
    int lo;
    int hi;
    case (kind)
      KIND_B_PTR: if (column <= NCOL) row_ptr[column] = index;
      KIND_B_ENTRY: if (index < NSLOT) begin
        slot_col[index] = column;
        slot_val[index] = value;
      end
      KIND_MAP: if (column < NCOL) remap[column] = mapped_column;
      KIND_A_NZ: begin
        if (column < NCOL) begin
          lo = row_ptr[column] > NSLOT ? NSLOT : int'(row_ptr[column]);
          hi = row_ptr[column+1] > NSLOT ? NSLOT : int'(row_ptr[column+1]);
          for (int k = lo; k < hi; k++)
            if (slot_col[k] < NCOL)
              mac(slot_col[k], longint'(value), longint'($signed(slot_val[k])));
        end
        if (row_end) drain_row();
      end
      KIND_EMPTY: drain_row();
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    product_t want;
    if (rst) begin
      map_on = 1'b0;
      tolerance = '0;
      clear_row();
      product_q.delete();
    end else begin
      if (write_enable) begin
        if (write_index == REG_USE_MAP) map_on = write_data[0];
        else tolerance = write_data;
      end
      if (strobe) begin
        if (product_q.size() == 0) begin
          report_miss("unexpected result, column", out_column, 0);
        end else begin
          want = product_q.pop_front();
          if (out_column != want.col) report_miss("column", out_column, want.col);
          if (out_value != want.val) report_miss("value", out_value, want.val);
          if (present != want.present) report_miss("present", present, want.present);
          if (last != want.last) report_miss("last", last, want.last);
        end
      end
      if (start && !busy) take_item();
    end
  end
endmodule
`default_nettype wire

// ----- dv/sparse_row_product_accumulator_tb.sv -----
`default_nettype none
// Top of the bench: clock, reset, stimulus and verdict. Prediction and
// comparison live in sparse_row_product_checker.
module sparse_row_product_accumulator_tb;
  import srpa_pkg::*;

  // B uses slots 0..B_USED-1 only; row pointers for rows 0..62 stay inside
  // that window so no walk touches an unwritten slot. Row 63 is clamped
  // empty and row 62 straddles the clamp, so A never names column 62.
  localparam int B_USED      = 48;
  localparam int STRADDLE    = 62;
  // items for the random phases; the load and directed part add about 200
  localparam int ITEM_TARGET = 270;
  localparam int IDLE_LIMIT  = 5000;
  localparam logic [2:0] KIND_SPARE = 3'd5;  // 5..7 are unused

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [2:0]         kind = '0;
  logic [10:0]        index = '0;
  logic [6:0]         column = '0;
  logic [15:0]        mapped_column = '0;
  logic signed [31:0] value = '0;
  logic               row_end = 1'b0;
  logic               write_enable = 1'b0;
  logic               write_index = 1'b0;
  logic [30:0]        write_data = '0;
  wire logic          busy;
  wire logic          strobe;
  wire logic [15:0]   out_column;
  wire logic signed [47:0] out_value;
  wire logic          present;
  wire logic          last;
  int                 errors;
  int                 pending;
  int                 stall_count = 0;
  bit                 no_gaps = 1'b0;

  always #5 clk = ~clk;

  sparse_row_product_accumulator u_top (
    .clk, .rst, .start, .busy, .kind, .index, .column, .mapped_column, .value,
    .row_end, .write_enable, .write_index, .write_data, .strobe, .out_column,
    .out_value, .present, .last
  );

  sparse_row_product_checker u_check (
    .clk, .rst, .start, .busy, .kind, .index, .column, .mapped_column, .value,
    .row_end, .write_enable, .write_index, .write_data, .strobe, .out_column,
    .out_value, .present, .last, .errors, .pending
  );

  // Watchdog: any accepted item, write or result resets the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || write_enable) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= IDLE_LIMIT) begin
      $display("sparse_row_product_accumulator verification failed");
      $finish;
    end
  end

  // Holds start high until the item is taken; start is left high so a
  // following item goes back to back.
  task automatic send(logic [2:0] k, logic [10:0] ix, logic [6:0] c,
                      logic [15:0] m, logic [31:0] v, logic re);
    kind <= k;
    index <= ix;
    column <= c;
    mapped_column <= m;
    value <= v;
    row_end <= re;
    if (!start) start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!no_gaps && $urandom_range(99) < 27) pause($urandom_range(1, 4));
  endtask

  // Wait until every predicted result is out, plus a margin for a drain that
  // may still be running after its last result.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (busy || pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic ix, logic [30:0] d);
    write_enable <= 1'b1;
    write_index <= ix;
    write_data <= d;
    @(posedge clk);
    write_enable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? $urandom_range(262143) : -$urandom_range(262143);
      1: return $urandom;
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return ($urandom_range(1) ? 1 : -1) * ($urandom_range(1, 16) << 16);
    endcase
  endfunction

  function automatic logic [6:0] pick_a_column();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 7'(63);
    if (r < 10) return 7'($urandom_range(64, 127));
    return 7'($urandom_range(STRADDLE - 1));
  endfunction

  // Reload noise that keeps the B window rules intact.
  task automatic send_reload();
    case ($urandom_range(3))
      0: send(KIND_B_PTR, 11'($urandom_range(B_USED)), 7'($urandom_range(STRADDLE)),
              16'($urandom), $urandom, 1'($urandom));
      1: send(KIND_B_ENTRY, 11'($urandom_range(B_USED - 1)), 7'($urandom_range(70)),
              16'($urandom), pick_value(), 1'($urandom));
      2: send(KIND_MAP, 11'($urandom), 7'($urandom), 16'($urandom), $urandom,
              1'($urandom));
      default: send(KIND_SPARE + 3'($urandom_range(2)), 11'($urandom), 7'($urandom),
                    16'($urandom), $urandom, 1'($urandom));
    endcase
  endtask

  task automatic random_phase(int n_items);
    int done;
    int len;
    done = 0;
    while (done < n_items) begin
      if (done > n_items / 3 && done < n_items / 2) no_gaps = 1'b1;
      else no_gaps = 1'b0;
      if ($urandom_range(99) < 10) begin
        send_reload();
        done++;
      end else if ($urandom_range(99) < 8) begin
        send(KIND_EMPTY, 11'($urandom), 7'($urandom), 16'($urandom), $urandom,
             1'($urandom));
        done++;
      end else begin
        // a well formed A row of a few nonzeros, last one closing it
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          send(KIND_A_NZ, 11'($urandom), pick_a_column(), 16'($urandom), pick_value(),
               i == len - 1);
          done++;
          maybe_gap();
        end
      end
      maybe_gap();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_USE_MAP, 31'd0);
    write_reg(REG_ZERO_TOL, 31'd0);

    // B load: rows 1..61 random inside the window, row 0 on the big slots.
    send(KIND_B_PTR, 11'd0, 7'd0, 16'($urandom), $urandom, 1'b1);
    send(KIND_B_PTR, 11'd4, 7'd1, 16'($urandom), $urandom, 1'b0);
    for (int r = 2; r <= STRADDLE; r++) begin
      send(KIND_B_PTR, 11'($urandom_range(B_USED)), 7'(r), 16'($urandom), $urandom,
           1'($urandom));
      maybe_gap();
    end
    send(KIND_B_PTR, 11'h7FF, 7'd63, 16'($urandom), $urandom, 1'b0);
    send(KIND_B_PTR, 11'd1030, 7'd64, 16'($urandom), $urandom, 1'b0);
    for (int s = 0; s < B_USED; s++) begin
      if (s < 4)
        send(KIND_B_ENTRY, 11'(s), 7'(s * 9), 16'($urandom), 32'h7FFF_FFFF, 1'b1);
      else
        send(KIND_B_ENTRY, 11'(s), 7'($urandom_range(s % 8 == 0 ? 127 : 63)),
             16'($urandom), pick_value(), 1'($urandom));
      maybe_gap();
    end
    for (int m = 0; m < 64; m++) begin
      send(KIND_MAP, 11'($urandom), 7'(m), 16'($urandom), $urandom, 1'($urandom));
      maybe_gap();
    end

    // Directed: ignored items, out of range fields, markers, ties, saturation.
    send(KIND_B_PTR, 11'd5, 7'd100, 16'($urandom), $urandom, 1'b1);
    send(KIND_B_ENTRY, 11'd1500, 7'd3, 16'($urandom), 32'h1234_5678, 1'b1);
    send(KIND_MAP, 11'($urandom), 7'd90, 16'hFFFF, $urandom, 1'b1);
    for (int k = 0; k < 3; k++)
      send(KIND_SPARE + 3'(k), 11'h7FF, 7'h7F, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send(KIND_A_NZ, '0, 7'd100, '0, 32'h0001_0000, 1'b1);
    send(KIND_EMPTY, '0, '0, '0, '0, 1'b0);
    send(KIND_A_NZ, '0, 7'd63, '0, 32'h0001_0000, 1'b1);
    send(KIND_A_NZ, '0, 7'd0, '0, 32'h7FFF_FFFF, 1'b0);
    send(KIND_A_NZ, '0, 7'd0, '0, 32'h7FFF_FFFF, 1'b0);
    send(KIND_A_NZ, '0, 7'd0, '0, 32'h7FFF_FFFF, 1'b1);
    send(KIND_A_NZ, '0, 7'd0, '0, 32'h8000_0000, 1'b0);
    send(KIND_A_NZ, '0, 7'd0, '0, 32'h8000_0000, 1'b0);
    send(KIND_A_NZ, '0, 7'd0, '0, 32'h8000_0000, 1'b0);
    send(KIND_EMPTY, '0, '0, '0, '0, 1'b1);
    // exact halves: B slot 0 rewritten to 0.5, A = +/- one LSB and three LSB
    send(KIND_B_ENTRY, 11'd0, 7'd5, '0, 32'h0000_8000, 1'b0);
    send(KIND_A_NZ, '0, 7'd0, '0, 32'h0000_0001, 1'b1);
    send(KIND_A_NZ, '0, 7'd0, '0, 32'hFFFF_FFFF, 1'b1);
    send(KIND_A_NZ, '0, 7'd0, '0, 32'h0000_0003, 1'b1);
    send(KIND_B_ENTRY, 11'd0, 7'd0, '0, 32'h7FFF_FFFF, 1'b0);
    settle();

    // Random phases across the register space, extremes included.
    random_phase(ITEM_TARGET / 4);
    settle();
    write_reg(REG_USE_MAP, 31'd1);
    write_reg(REG_ZERO_TOL, 31'($urandom_range(65535)));
    random_phase(ITEM_TARGET / 4);
    settle();
    write_reg(REG_ZERO_TOL, 31'h7FFF_FFFF);
    random_phase(ITEM_TARGET / 8);
    settle();
    write_reg(REG_USE_MAP, 31'd0);
    write_reg(REG_ZERO_TOL, 31'($urandom_range(200000)));
    random_phase(ITEM_TARGET / 8);
    settle();
    write_reg(REG_ZERO_TOL, 31'd0);
    random_phase(ITEM_TARGET / 4);

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("sparse_row_product_accumulator verification clean");
    end else begin
      $display("sparse_row_product_accumulator verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
